// ----- sv/msd_pkg.sv -----
// Shared types, constants and the sine table for the modulated stereo delay.
// No dependencies; used by modulated_stereo_delay.
package msd_pkg;

  localparam int unsigned DelayDepth = 8192;
  localparam int unsigned AddrW      = $clog2(DelayDepth);
  localparam int unsigned MinDelay   = 80;
  localparam int unsigned SineSize   = 1024;
  localparam int unsigned SineW      = $clog2(SineSize);
  localparam int unsigned PhaseW     = 24;
  localparam int unsigned PhFracW    = PhaseW - SineW;
  localparam int unsigned SmoothW    = AddrW + 16;

  // Q16 gain of 1.1, smoothing coefficient 0.0005 in Q0.24
  localparam int unsigned Gain11     = 72090;
  localparam int unsigned SmoothCoef = 8389;
  // r^2 / 819200 = (r^2 >> 15) / 25, the /25 as a reciprocal multiply
  localparam int unsigned LfoPreShift = 15;
  localparam int unsigned LfoRecip    = 167773;
  localparam int unsigned LfoRecShift = 22;

  localparam logic [1:0] ModeOpen    = 2'd0;
  localparam logic [1:0] ModeClassic = 2'd1;
  localparam logic [1:0] ModePing    = 2'd2;

  localparam logic [2:0] RegMode     = 3'd0;
  localparam logic [2:0] RegDelay    = 3'd1;
  localparam logic [2:0] RegFeedback = 3'd2;
  localparam logic [2:0] RegLfoRate  = 3'd3;
  localparam logic [2:0] RegLfoDepth = 3'd4;

  localparam int unsigned PaddrW = 5;

  typedef struct packed {
    logic signed [15:0] in_left;
    logic signed [15:0] in_right;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
  } out_t;

  typedef logic signed [16:0] sine_tab_t [0:SineSize];

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Taylor series of sin over the first quadrant, rounded to Q1.15
  function automatic logic signed [16:0] quarter_sine(logic [63:0] num);
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] v;
    x    = num * HalfPiQ30 / SineSize;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 5; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        default: term = term / 110;
      endcase
      if ((k % 2) == 1) sum = sum - signed'(term);
      else              sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    v = (unsigned'(sum) + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return 17'(v);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    logic [63:0] q4;
    logic [63:0] quad;
    logic [63:0] r;
    logic signed [16:0] v;
    for (int i = 0; i <= SineSize; i++) begin
      q4   = 64'(4 * i);
      quad = q4 / SineSize;
      r    = q4 - quad * SineSize;
      if (quad[0]) v = quarter_sine(64'(SineSize) - r);
      else         v = quarter_sine(r);
      t[i] = quad[1] ? -v : v;
    end
    return t;
  endfunction

  localparam sine_tab_t SineTab = build_sine();

endpackage

// ----- sv/modulated_stereo_delay.sv -----
// Modulated stereo delay: sequencer around one shared multiplier, delay memory
// and sine ROM. Depends on msd_pkg.
//
//   channel   signals                        dir   notes
//   input     in_valid_i/in_ready_o/in_req_i  in   one stereo frame per request
//   output    out_valid_o/out_ready_i/out_rsp_o out one result per frame
//   config    psel/penable/pwrite/paddr/...   in   APB, 5 registers at 4*i
//
// A frame runs through 20 sequencer steps after the accepting idle cycle, and
// no new frame is accepted until the sequencer is back in idle. The result
// sits in an output register; the next request is taken while it waits, and
// the sequencer only holds in its last step if the previous result is still
// untaken. Reset needs no clearing pass: the memory is tracked by the write
// cursor and a wrap flag, and entries not yet written read as zero.
module modulated_stereo_delay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  msd_pkg::in_t                  in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output msd_pkg::out_t                 out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msd_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import msd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GAIN, ST_KSQ, ST_BASE, ST_RSQ, ST_STEP, ST_DSQ, ST_AMP, ST_SINE,
    ST_SAMP, ST_TGT, ST_SMOOTH, ST_UPD, ST_CLAMP, ST_RDA, ST_CHL, ST_CHR, ST_WR,
    ST_INTL, ST_INTR, ST_DONE
  } state_e;

  state_e state_q;

  logic [1:0]  mode_q;
  logic [15:0] delay_knob_q, fb_knob_q, rate_knob_q, depth_knob_q;

  in_t                in_q;
  logic [16:0]        g_q;
  logic [29:0]        base_q;
  logic [12:0]        lfo_step_q;
  logic [26:0]        amp_q;
  logic signed [16:0] sa_q, sb_q, s_q;
  logic signed [31:0] delta_q;
  logic [SmoothW-1:0] smoothed_q;
  logic [PhaseW-1:0]  phase_q;
  logic [AddrW-1:0]   cur_q, ix_q;
  logic               wrapped_q;
  logic [15:0]        frac_q;
  logic signed [15:0] held_l_q, held_r_q, fbl_new_q;
  logic signed [15:0] wl_q, outr_q;
  logic signed [15:0] al_q, ar_q, bl_q, br_q;
  out_t               out_q;
  logic               out_valid_q;

  logic signed [33:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [61:0] prod_q;

  logic [31:0]        mem_q [DelayDepth];
  logic [31:0]        rd_q;
  logic               rd_ok_q;
  logic [AddrW-1:0]   raddr;
  logic               mem_we;
  logic [31:0]        mem_wdata;

  logic signed [16:0] rom_q;
  logic [SineW:0]     rom_addr;

  logic [31:0]        rd_data;
  logic signed [15:0] wr_d;
  logic signed [31:0] target_d;
  logic [SmoothW-1:0] smoothed_d;

  // (a * 2^16 + p) / 2^16 truncated toward zero, then saturated
  function automatic logic signed [15:0] mix_sat(logic signed [15:0] a,
                                                 logic signed [61:0] p);
    logic signed [47:0] total;
    logic signed [47:0] q;
    total = 48'(signed'({a, 16'h0000})) + 48'(p);
    q     = (total + (total < 0 ? 48'sd65535 : 48'sd0)) >>> 16;
    if (q > 48'sd32767)       return 16'sh7fff;
    else if (q < -48'sd32768) return 16'sh8000;
    else                      return 16'(q);
  endfunction

  // APB
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[PaddrW-1:2])
      RegMode:     prdata = {30'd0, mode_q};
      RegDelay:    prdata = {16'd0, delay_knob_q};
      RegFeedback: prdata = {16'd0, fb_knob_q};
      RegLfoRate:  prdata = {16'd0, rate_knob_q};
      RegLfoDepth: prdata = {16'd0, depth_knob_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeClassic;
      delay_knob_q <= '0;
      fb_knob_q    <= '0;
      rate_knob_q  <= '0;
      depth_knob_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[PaddrW-1:2])
        RegMode:     mode_q       <= pwdata[1:0];
        RegDelay:    delay_knob_q <= pwdata[15:0];
        RegFeedback: fb_knob_q    <= pwdata[15:0];
        RegLfoRate:  rate_knob_q  <= pwdata[15:0];
        RegLfoDepth: depth_knob_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign rd_data = rd_ok_q ? rd_q : 32'd0;

  // shared multiplier operand select and read addresses
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = {1'b0, phase_q[PhaseW-1:PhFracW]};
    raddr    = ix_q - AddrW'(1);
    unique case (state_q)
      ST_GAIN: begin
        mul_a = 34'(fb_knob_q);
        mul_b = 28'(Gain11);
      end
      ST_KSQ: begin
        mul_a    = 34'(delay_knob_q);
        mul_b    = 28'(delay_knob_q);
        rom_addr = {1'b0, phase_q[PhaseW-1:PhFracW]} + (SineW+1)'(1);
      end
      ST_BASE: begin
        mul_a = 34'(prod_q[31:0]);
        mul_b = 28'(DelayDepth - 1 - MinDelay);
      end
      ST_RSQ: begin
        mul_a = 34'(rate_knob_q);
        mul_b = 28'(rate_knob_q);
      end
      ST_STEP: begin
        mul_a = 34'(prod_q[31:LfoPreShift]);
        mul_b = 28'(LfoRecip);
      end
      ST_DSQ: begin
        mul_a = 34'(depth_knob_q);
        mul_b = 28'(depth_knob_q);
      end
      ST_AMP: begin
        mul_a = 34'(prod_q[31:0]);
        mul_b = 28'(DelayDepth - 1);
      end
      ST_SINE: begin
        mul_a = 34'(18'(sb_q) - 18'(sa_q));
        mul_b = 28'(phase_q[PhFracW-1:0]);
      end
      ST_TGT: begin
        mul_a = 34'(s_q);
        mul_b = 28'(amp_q);
      end
      ST_UPD: begin
        mul_a = 34'(delta_q);
        mul_b = 28'(SmoothCoef);
      end
      ST_RDA: raddr = cur_q - smoothed_q[SmoothW-1:16];
      ST_CHL: begin
        unique case (mode_q)
          ModeOpen: mul_a = 34'(in_q.in_right);
          ModePing: mul_a = 34'(held_r_q);
          default:  mul_a = 34'(held_l_q);
        endcase
        mul_b = 28'(g_q);
      end
      ST_CHR: begin
        mul_a = (mode_q == ModePing) ? 34'(held_l_q) : 34'(held_r_q);
        mul_b = 28'(g_q);
      end
      ST_WR: begin
        mul_a = 34'(17'(bl_q) - 17'(al_q));
        mul_b = 28'(frac_q);
      end
      ST_INTL: begin
        mul_a = 34'(17'(br_q) - 17'(ar_q));
        mul_b = 28'(frac_q);
      end
      default: ;
    endcase
  end

  // target = base + trunc(s * amp / 2^15)
  always_comb begin
    logic signed [61:0] t;
    t        = (prod_q + (prod_q < 0 ? 62'sd32767 : 62'sd0)) >>> 15;
    target_d = 32'(base_q) + 32'(t);
  end

  // smoothing step, rounded half away from zero, then clamp
  always_comb begin
    logic [61:0]        mag;
    logic [61:0]        rnd;
    logic signed [33:0] stp;
    logic signed [33:0] sm;
    mag = (prod_q < 0) ? 62'(-prod_q) : 62'(prod_q);
    rnd = (mag + 62'd8388608) >> 24;
    stp = (prod_q < 0) ? -34'(rnd) : 34'(rnd);
    sm  = 34'(smoothed_q) + stp;
    if (sm < 34'(MinDelay << 16))               smoothed_d = SmoothW'(MinDelay << 16);
    else if (sm > 34'((DelayDepth - 1) << 16))  smoothed_d = SmoothW'((DelayDepth - 1) << 16);
    else                                        smoothed_d = SmoothW'(sm);
  end

  assign wr_d      = (mode_q == ModeOpen) ? held_l_q : mix_sat(in_q.in_right, prod_q);
  assign mem_we    = (state_q == ST_WR);
  assign mem_wdata = {wl_q, wr_d};

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    rom_q  <= SineTab[rom_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cur_q] <= mem_wdata;
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
      smoothed_q  <= '0;
      phase_q     <= '0;
      cur_q       <= '0;
      wrapped_q   <= 1'b0;
      held_l_q    <= '0;
      held_r_q    <= '0;
    end else begin
      // entries at or past the cursor are unwritten until the first wrap
      rd_ok_q <= wrapped_q || (raddr < cur_q);
      if (out_valid_q && out_ready_i && state_q != ST_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_req_i;
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN:  state_q <= ST_KSQ;
        ST_KSQ: begin
          g_q     <= 17'((prod_q[33:0] + 34'd32768) >> 16);
          sa_q    <= rom_q;
          state_q <= ST_BASE;
        end
        ST_BASE: begin
          sb_q    <= rom_q;
          state_q <= ST_RSQ;
        end
        ST_RSQ: begin
          base_q  <= 30'(MinDelay << 16) + 30'(prod_q[44:16]);
          state_q <= ST_STEP;
        end
        ST_STEP:  state_q <= ST_DSQ;
        ST_DSQ: begin
          lfo_step_q <= prod_q[LfoRecShift+12:LfoRecShift];
          state_q    <= ST_AMP;
        end
        ST_AMP:   state_q <= ST_SINE;
        ST_SINE: begin
          amp_q   <= prod_q[44:18];
          state_q <= ST_SAMP;
        end
        ST_SAMP: begin
          s_q     <= sa_q + 17'((prod_q + (prod_q < 0 ? 62'sd16383 : 62'sd0)) >>> PhFracW);
          state_q <= ST_TGT;
        end
        ST_TGT:   state_q <= ST_SMOOTH;
        ST_SMOOTH: begin
          delta_q <= target_d - 32'(smoothed_q);
          state_q <= ST_UPD;
        end
        ST_UPD:   state_q <= ST_CLAMP;
        ST_CLAMP: begin
          smoothed_q <= smoothed_d;
          state_q    <= ST_RDA;
        end
        ST_RDA: begin
          ix_q    <= raddr;
          frac_q  <= smoothed_q[15:0];
          state_q <= ST_CHL;
        end
        ST_CHL: begin
          al_q    <= rd_data[31:16];
          ar_q    <= rd_data[15:0];
          state_q <= ST_CHR;
        end
        ST_CHR: begin
          bl_q    <= rd_data[31:16];
          br_q    <= rd_data[15:0];
          wl_q    <= mix_sat(in_q.in_left, prod_q);
          state_q <= ST_WR;
        end
        ST_WR: begin
          outr_q  <= (mode_q == ModeOpen) ? held_r_q : wr_d;
          state_q <= ST_INTL;
        end
        ST_INTL: begin
          fbl_new_q <= mix_sat(al_q, prod_q);
          state_q   <= ST_INTR;
        end
        ST_INTR: begin
          held_l_q <= fbl_new_q;
          held_r_q <= mix_sat(ar_q, prod_q);
          phase_q  <= phase_q + PhaseW'(lfo_step_q);
          cur_q    <= cur_q + AddrW'(1);
          if (cur_q == AddrW'(DelayDepth - 1)) wrapped_q <= 1'b1;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.out_left  <= wl_q;
            out_q.out_right <= outr_q;
            out_valid_q     <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
